[design/rlbp_pkg.sv]
`default_nettype none

package rlbp_pkg;

   // Sizing limits of the packer
   localparam int MAX_WIDTH = 2048;
   localparam int MAX_LINES = 4096;
   localparam int WORD_BITS = 32;

   // Field widths
   localparam int RUN_W      = 16;
   localparam int CFG_W      = 12;
   localparam int IDX_W      = 6;
   localparam int LINE_W     = 12;
   localparam int FILL_W     = $clog2(WORD_BITS);
   // A drawn run never exceeds MAX_WIDTH, so it fits in this many bits
   localparam int DRAW_W     = $clog2(MAX_WIDTH) + 1;
   // Words caused by one run, including the flush word
   localparam int WCNT_W     = DRAW_W - FILL_W;
   localparam int LCMP_W     = $clog2(MAX_LINES) + 1 > LINE_W + 1 ?
                               $clog2(MAX_LINES) + 1 : LINE_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CFG_W;

   localparam logic [CFG_W-1:0]  LINE_WIDTH_RST  = 12'd1728;
   localparam logic [CFG_W-1:0]  PAGE_HEIGHT_RST = 12'd2339;
   localparam logic [LINE_W-1:0] LINE_LAST       = '1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LINE_WIDTH  = 2'd0,
      REG_PAGE_HEIGHT = 2'd1,
      REG_INVERSE     = 2'd2
   } rlbp_reg_type;

   // One classified run, ready for the packing back end
   typedef struct packed {
      logic              draw;
      logic              color;
      logic              finish;
      logic              newline;
      logic [DRAW_W-1:0] run_len;
      logic [LINE_W-1:0] line_number;
   } rlbp_cmd_type;

endpackage

`default_nettype wire

[design/rlbp_if.sv]
`default_nettype none

// Run input channel
interface rlbp_req_if import rlbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RUN_W-1:0] run_length;
   logic             line_end;

   modport source (output valid, run_length, line_end, input ready);
   modport sink (input valid, run_length, line_end, output ready);
endinterface

// Packed word output channel
interface rlbp_rsp_if import rlbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] pixel_word;
   logic [IDX_W-1:0]     word_index;
   logic [LINE_W-1:0]    line_number;
   logic                 line_done;
   logic                 last_of_run;

   modport source (output valid, pixel_word, word_index, line_number, line_done,
                   last_of_run, input ready);
   modport sink (input valid, pixel_word, word_index, line_number, line_done,
                 last_of_run, output ready);
   modport monitor (input valid, ready, pixel_word, word_index, line_number,
                    line_done, last_of_run);
endinterface

// Register write channel
interface rlbp_csr_if import rlbp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/rlbp_front.sv]
`default_nettype none

module rlbp_front import rlbp_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   rlbp_req_if.sink     req_chan,
   rlbp_csr_if.sink     csr_chan,
   input  wire          queue_full,
   output logic         push,
   output rlbp_cmd_type push_cmd
);

   logic [CFG_W-1:0]  line_width_ff, line_width_in;
   logic [CFG_W-1:0]  page_height_ff, page_height_in;
   logic              inverse_ff, inverse_in;
   logic [CFG_W-1:0]  pixel_total_ff, pixel_total_in;
   logic              color_ff, color_in;
   logic              complete_ff, complete_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic [CFG_W-1:0]  width_eff;
   logic [RUN_W:0]    run_sum;
   logic              drawable;
   logic              active;
   logic              overshoot;
   logic              draw;
   logic              finish;
   logic              req_fire;
   logic              csr_fire;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid;

   // Classify the run against the line state
   always_comb begin
      width_eff = (line_width_ff > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : line_width_ff;
      run_sum   = (RUN_W+1)'(pixel_total_ff) + (RUN_W+1)'(req_chan.run_length);
      drawable  = (line_ff < page_height_ff) && (LCMP_W'(line_ff) < LCMP_W'(MAX_LINES));
      active    = drawable && !complete_ff;
      overshoot = (pixel_total_ff >= width_eff) || (run_sum > (RUN_W+1)'(width_eff));
      draw      = active && !overshoot;
      finish    = active && (overshoot || req_chan.line_end ||
                             (run_sum == (RUN_W+1)'(width_eff)));
   end

   assign push                 = req_fire;
   assign push_cmd.draw        = draw;
   assign push_cmd.color       = color_ff;
   assign push_cmd.finish      = finish;
   assign push_cmd.newline     = req_chan.line_end;
   assign push_cmd.run_len     = req_chan.run_length[DRAW_W-1:0];
   assign push_cmd.line_number = line_ff;

   // Line state and register updates
   always_comb begin
      line_width_in  = line_width_ff;
      page_height_in = page_height_ff;
      inverse_in     = inverse_ff;
      pixel_total_in = pixel_total_ff;
      color_in       = color_ff;
      complete_in    = complete_ff;
      line_in        = line_ff;
      if (req_fire) begin
         if (req_chan.line_end) begin
            pixel_total_in = '0;
            color_in       = inverse_ff;
            complete_in    = 1'b0;
            if (line_ff != LINE_LAST) begin
               line_in = line_ff + 1'b1;
            end
         end else begin
            if (draw) begin
               pixel_total_in = run_sum[CFG_W-1:0];
               color_in       = !color_ff;
            end
            complete_in = complete_ff || finish;
         end
      end
      if (csr_fire) begin
         case (rlbp_reg_type'(csr_chan.index))
            REG_LINE_WIDTH: begin
               line_width_in = csr_chan.data;
            end
            REG_PAGE_HEIGHT: begin
               page_height_in = csr_chan.data;
            end
            REG_INVERSE: begin
               inverse_in = csr_chan.data[0];
               color_in   = color_in ^ inverse_ff ^ csr_chan.data[0];
            end
            default: begin
               line_width_in = line_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= LINE_WIDTH_RST;
         page_height_ff <= PAGE_HEIGHT_RST;
         inverse_ff     <= 1'b0;
         pixel_total_ff <= '0;
         color_ff       <= 1'b0;
         complete_ff    <= 1'b0;
         line_ff        <= '0;
      end else begin
         line_width_ff  <= line_width_in;
         page_height_ff <= page_height_in;
         inverse_ff     <= inverse_in;
         pixel_total_ff <= pixel_total_in;
         color_ff       <= color_in;
         complete_ff    <= complete_in;
         line_ff        <= line_in;
      end
   end

endmodule

`default_nettype wire

[design/rlbp_queue.sv]
`default_nettype none

module rlbp_queue import rlbp_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  rlbp_cmd_type push_cmd,
   input  wire          pop,
   output rlbp_cmd_type head_cmd,
   output logic         empty,
   output logic         full
);

   rlbp_cmd_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];

   // Pointer and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[design/rlbp_back.sv]
`default_nettype none

module rlbp_back import rlbp_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  rlbp_cmd_type head_cmd,
   input  wire          empty,
   output logic         pop,
   rlbp_rsp_if.source   rsp_chan
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [WORD_BITS-1:0] acc_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [IDX_W-1:0]     next_word_ff;
   logic [WORD_BITS-1:0] first_word_ff;
   logic [WORD_BITS-1:0] solid_ff;
   logic [WCNT_W-1:0]    remain_ff;
   logic                 first_ff;
   logic                 finish_ff;
   logic                 newline_ff;
   logic [LINE_W-1:0]    line_ff;

   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_word_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [LINE_W-1:0]    rsp_line_ff;
   logic                 rsp_done_ff;
   logic                 rsp_last_ff;

   logic [WORD_BITS-1:0] fill_mask;
   logic [WORD_BITS-1:0] merged;
   logic [WORD_BITS-1:0] solid;
   logic [DRAW_W-1:0]    bit_sum;
   logic [WCNT_W-1:0]    full_words;
   logic [FILL_W-1:0]    new_fill;
   logic                 flush;
   logic [WCNT_W-1:0]    total;
   logic                 slot_free;
   logic                 emit_fire;
   logic                 emit_last;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_word  = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_index_ff;
   assign rsp_chan.line_number = rsp_line_ff;
   assign rsp_chan.line_done   = rsp_done_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

   assign pop       = (state_ff == ST_IDLE) && !empty;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit_fire = (state_ff == ST_EMIT) && slot_free;
   assign emit_last = (remain_ff == WCNT_W'(1));

   // Merge the run color into the partial word and count the words it makes
   always_comb begin
      fill_mask  = {WORD_BITS{1'b1}} >> fill_ff;
      solid      = {WORD_BITS{head_cmd.color}};
      if (head_cmd.draw) begin
         merged  = head_cmd.color ? (acc_ff | fill_mask) : (acc_ff & ~fill_mask);
         bit_sum = DRAW_W'(fill_ff) + head_cmd.run_len;
      end else begin
         merged  = acc_ff;
         bit_sum = DRAW_W'(fill_ff);
      end
      full_words = bit_sum[DRAW_W-1:FILL_W];
      new_fill   = bit_sum[FILL_W-1:0];
      flush      = head_cmd.finish && (new_fill != '0);
      total      = full_words + WCNT_W'(flush);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         fill_ff      <= '0;
         next_word_ff <= '0;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         // Output register drains independently of the sequencer
         if (!emit_fire && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head_cmd.finish || head_cmd.newline) begin
                     acc_ff  <= '0;
                     fill_ff <= '0;
                  end else begin
                     acc_ff  <= (full_words != '0) ? solid : merged;
                     fill_ff <= new_fill;
                  end
                  first_word_ff <= merged;
                  solid_ff      <= solid;
                  remain_ff     <= total;
                  first_ff      <= 1'b1;
                  finish_ff     <= head_cmd.finish;
                  newline_ff    <= head_cmd.newline;
                  line_ff       <= head_cmd.line_number;
                  if (total != '0) begin
                     state_ff <= ST_EMIT;
                  end else if (head_cmd.newline) begin
                     next_word_ff <= '0;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= first_ff ? first_word_ff : solid_ff;
                  rsp_index_ff <= next_word_ff;
                  rsp_line_ff  <= line_ff;
                  rsp_done_ff  <= emit_last && finish_ff;
                  rsp_last_ff  <= emit_last;
                  first_ff     <= 1'b0;
                  remain_ff    <= remain_ff - 1'b1;
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end
                  // Word index restarts on a new line
                  if (emit_last && newline_ff) begin
                     next_word_ff <= '0;
                  end else begin
                     next_word_ff <= next_word_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[design/run_length_to_bitmap_packer.sv]
// Run-length to bitmap word packer.
// req_chan carries one run per word: run_length pixels of the current color,
// colors alternating from white (black when inverse is set) at each line start;
// line_end marks the last run of a scan line. rsp_chan returns 32-pixel words,
// first pixel at bit 31, with their index in the line, the line number, and
// flags for the line's last word and the run's last word. csr_chan writes
// line_width (0), page_height (1) and inverse (2); write only while idle.
// A combinational front stage classifies each run against the line state and
// hands a command to a four-entry queue, so runs are taken one per cycle
// while the queue has room. The back end packs one command at a time: its
// idle state pops the command and merges the run into the partial word, then
// its emit state offers each output word in turn, and only after the run's
// last word does it pop the next command. Words leave from an output register.
// Reset (synchronous) restores the register defaults, clears the line state
// and empties the queue. When the receiver stalls, the word is held in the
// output register, the back end waits, and the queue keeps taking runs until
// it fills.
`default_nettype none

module run_length_to_bitmap_packer import rlbp_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   rlbp_req_if.sink   req_chan,
   rlbp_rsp_if.source rsp_chan,
   rlbp_csr_if.sink   csr_chan
);

   rlbp_cmd_type push_cmd;
   rlbp_cmd_type head_cmd;
   logic         push;
   logic         pop;
   logic         empty;
   logic         full;

   rlbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   rlbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty),
      .full     (full)
   );

   rlbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[design/rlbp_checker.sv]
`default_nettype none

module rlbp_checker import rlbp_pkg::*; (
   input wire             clock,
   input wire             reset,
   input wire             rsp_valid,
   input wire             rsp_ready,
   input wire [IDX_W-1:0] rsp_word_index,
   input wire             rsp_line_done,
   input wire             rsp_last_of_run
);

   // Nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word valid right after reset");

   // A stalled word stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // Words of one run follow back to back with consecutive indexes
   a_run_words_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         rsp_valid &&
         (rsp_word_index == IDX_W'($past(rsp_word_index) + 1'b1)))
      else $error("gap or index skip inside one run's words");

   // The word that ends a line is also the last word of its run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_last_of_run)
      else $error("line_done on a word that is not the run's last");

endmodule

bind run_length_to_bitmap_packer rlbp_checker u_rlbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_word_index  (rsp_chan.word_index),
   .rsp_line_done   (rsp_chan.line_done),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import rlbp_pkg::*;

   // One pending run; a hold entry makes the sender wait for all words to drain
   typedef struct packed {
      logic [RUN_W-1:0] run_length;
      logic             line_end;
      logic             hold;
   } run_item_type;

   // One packed pixel word as the block returns it
   typedef struct packed {
      logic [WORD_BITS-1:0] pixel_word;
      logic [IDX_W-1:0]     word_index;
      logic [LINE_W-1:0]    line_number;
      logic                 line_done;
      logic                 last_of_run;
   } pixel_out_type;

   typedef enum int {SINK_ALWAYS, SINK_BUSY, SINK_PERIODIC, SINK_SPARSE} sink_mode_type;

   localparam int SETTLE_LIMIT = 100000;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_CYCLES = 300;

   logic clock;
   logic reset;

   rlbp_req_if req_chan ();
   rlbp_rsp_if rsp_chan ();
   rlbp_csr_if csr_chan ();

   run_length_to_bitmap_packer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Pending runs, and packed words still owed by the block
   run_item_type  run_queue[$];
   pixel_out_type expected_words[$];
   pixel_out_type step_words[$];

   // Packer state as predicted
   logic [CFG_W-1:0]     cfg_line_width;
   logic [CFG_W-1:0]     cfg_page_height;
   logic                 cfg_inverse;
   logic [WORD_BITS-1:0] acc_word;
   int                   acc_fill;
   logic                 run_color;
   int                   line_pixels;
   logic [IDX_W-1:0]     word_pos;
   logic [LINE_W-1:0]    line_num;
   logic                 line_closed;

   int            error_count = 0;
   int            words_checked = 0;
   int            runs_taken = 0;
   int            lines_taken = 0;
   int            queued_runs = 0;
   logic          req_fired;
   int            gap_left = 0;
   int            burst_left = 0;
   bit            src_gaps = 1'b1;
   sink_mode_type sink_mode = SINK_BUSY;
   bit            stall_request = 1'b0;
   int            stall_left = 0;
   int            sink_tick = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Append one packed word for the current run
   function automatic void put_word(input logic [WORD_BITS-1:0] bits, input logic done);
      pixel_out_type pw;
      if (step_words.size() >= 64) return;
      pw.pixel_word  = bits;
      pw.word_index  = word_pos;
      pw.line_number = line_num;
      pw.line_done   = done;
      pw.last_of_run = 1'b0;
      step_words.push_back(pw);
      word_pos++;
   endfunction

   // End of line: flush the partial word, or flag the last word already out
   function automatic void close_line();
      pixel_out_type pw;
      if (acc_fill != 0) begin
         put_word(acc_word, 1'b1);
      end else if (step_words.size() > 0) begin
         pw = step_words[step_words.size()-1];
         pw.line_done = 1'b1;
         step_words[step_words.size()-1] = pw;
      end
      acc_fill    = 0;
      acc_word    = '0;
      line_closed = 1'b1;
   endfunction

   // Predict the packed words caused by one run
   function automatic void pack_run(input int n, input logic le);
      int                   w;
      int                   rest;
      bit                   drawable;
      logic [WORD_BITS-1:0] solid;
      pixel_out_type        pw;
      w = (cfg_line_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_line_width);
      drawable = (line_num < cfg_page_height) && (int'(line_num) < MAX_LINES);
      step_words.delete();
      if (drawable && !line_closed) begin
         if (line_pixels >= w || line_pixels + n > w) begin
            // overshoot, or width already used up: line ends undrawn
            close_line();
         end else begin
            solid = run_color ? '1 : '0;
            // padding beyond the fill takes this run's color
            if (run_color)
               acc_word |= 32'hFFFF_FFFF >> acc_fill;
            else if (acc_fill != 0)
               acc_word &= 32'hFFFF_FFFF << (WORD_BITS - acc_fill);
            else
               acc_word = '0;
            if (acc_fill + n < WORD_BITS) begin
               acc_fill += n;
            end else begin
               put_word(acc_word, 1'b0);
               rest = n - (WORD_BITS - acc_fill);
               while (rest >= WORD_BITS) begin
                  put_word(solid, 1'b0);
                  rest -= WORD_BITS;
               end
               acc_word = solid;
               acc_fill = rest;
            end
            line_pixels += n;
            run_color = ~run_color;
            if (line_pixels == w) close_line();
         end
      end
      if (le) begin
         if (drawable && !line_closed) close_line();
         acc_word    = '0;
         acc_fill    = 0;
         run_color   = cfg_inverse;
         line_pixels = 0;
         word_pos    = '0;
         line_closed = 1'b0;
         if (line_num < LINE_LAST) line_num++;
      end
      if (step_words.size() > 0) begin
         pw = step_words[step_words.size()-1];
         pw.last_of_run = 1'b1;
         step_words[step_words.size()-1] = pw;
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Run acceptance: predict at the edge the word is taken
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            pack_run(int'(req_chan.run_length), req_chan.line_end);
            runs_taken++;
            if (req_chan.line_end) lines_taken++;
         end
      end
   end

   // Run driver: bursts of words with random gaps
   always @(negedge clock) begin
      run_item_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (run_queue.size() > 0 && run_queue[0].hold) begin
            // wait here until the block has returned every word
            req_chan.valid <= 1'b0;
            if (expected_words.size() == 0) void'(run_queue.pop_front());
         end else if (run_queue.size() > 0) begin
            item = run_queue.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.run_length <= item.run_length;
            req_chan.line_end   <= item.line_end;
            if (burst_left > 0) begin
               burst_left--;
            end else if (src_gaps) begin
               gap_left   = $urandom_range(1, 6);
               burst_left = $urandom_range(0, 30);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Word receiver: stall pattern per mode, plus a long hold-off on request
   always @(negedge clock) begin
      sink_tick++;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_request) begin
         stall_request = 1'b0;
         stall_left = STALL_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (sink_mode)
            SINK_ALWAYS:   rsp_chan.ready <= 1'b1;
            SINK_BUSY:     rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            SINK_PERIODIC: rsp_chan.ready <= ((sink_tick % 7) < 4);
            default:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Word checker
   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word 0x%0h on line %0d, nothing expected",
                   rsp_chan.pixel_word, rsp_chan.line_number);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("pixel_word", want.pixel_word, rsp_chan.pixel_word);
            check_field("word_index", want.word_index, rsp_chan.word_index);
            check_field("line_number", want.line_number, rsp_chan.line_number);
            check_field("line_done", want.line_done, rsp_chan.line_done);
            check_field("last_of_run", want.last_of_run, rsp_chan.last_of_run);
            words_checked++;
         end
      end
   end

   task automatic add_run(input logic [RUN_W-1:0] n, input logic le);
      run_item_type item;
      item.run_length = n;
      item.line_end   = le;
      item.hold       = 1'b0;
      run_queue.push_back(item);
      queued_runs++;
   endtask

   task automatic add_hold();
      run_item_type item;
      item = '0;
      item.hold = 1'b1;
      run_queue.push_back(item);
   endtask

   // Wait until every run is taken and every word is back, then let the block go quiet
   task automatic settle();
      int waited;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while ((run_queue.size() != 0 || req_chan.valid || expected_words.size() != 0)
                 && waited < SETTLE_LIMIT);
      if (waited >= SETTLE_LIMIT) begin
         $error("block went silent with %0d words outstanding", expected_words.size());
         error_count++;
         expected_words.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, only once the block is idle
   task automatic write_reg(input rlbp_reg_type idx, input logic [CFG_W-1:0] value);
      settle();
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_LINE_WIDTH:  cfg_line_width  = value;
         REG_PAGE_HEIGHT: cfg_page_height = value;
         REG_INVERSE: begin
            // colors of the rest of the line swap at once
            run_color   = run_color ^ cfg_inverse ^ value[0];
            cfg_inverse = value[0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Queue the runs of one scan line, mostly well formed
   task automatic queue_line(input int w);
      int left;
      int n;
      int cap;
      int kind;
      kind = $urandom_range(0, 9);
      left = w;
      case (kind)
         0, 1, 2, 3, 4, 5: begin
            // runs that fill the width exactly
            if (left == 0) add_run($urandom_range(0, 5), 1'b1);
            while (left > 0) begin
               cap = ($urandom_range(0, 3) == 0 || left < 40) ? left : 40;
               n = $urandom_range(0, cap);
               left -= n;
               add_run(n, left == 0 && kind != 5);
            end
            // runs after a full line are dropped up to line_end
            if (kind == 5) begin
               add_run($urandom_range(0, 40), 1'b0);
               add_run($urandom, 1'b1);
            end
         end
         6: begin
            // line cut short by line_end
            repeat ($urandom_range(0, 4)) add_run($urandom_range(0, 20), 1'b0);
            add_run($urandom_range(0, 20), 1'b1);
         end
         7: begin
            // a run past the width ends the line undrawn
            n = $urandom_range(0, w);
            add_run(n, 1'b0);
            add_run(w - n + 1 + $urandom_range(0, 50), 1'b0);
            add_run($urandom_range(0, 9), 1'b1);
         end
         8: begin
            repeat ($urandom_range(1, 4)) add_run($urandom, $urandom_range(0, 1));
            add_run($urandom, 1'b1);
         end
         default: begin
            repeat (2) add_run($urandom_range(0, w), 1'b0);
            add_run($urandom_range(0, w), 1'b1);
         end
      endcase
   endtask

   task automatic random_phase(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                               input logic inv, input sink_mode_type mode, input bit gaps,
                               input bit pressure, input int n_runs);
      int w;
      int stop_at;
      write_reg(REG_LINE_WIDTH, width);
      write_reg(REG_PAGE_HEIGHT, height);
      write_reg(REG_INVERSE, inv);
      sink_mode = mode;
      src_gaps  = gaps;
      w = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
      stop_at = queued_runs + n_runs;
      // long receiver hold-off while the sender keeps offering runs
      if (pressure) stall_request = 1'b1;
      while (queued_runs < stop_at) begin
         queue_line(w);
         if (pressure && queued_runs >= stop_at - n_runs / 2) begin
            add_hold();
            pressure = 1'b0;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.run_length = '0;
      req_chan.line_end   = 1'b0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = REG_LINE_WIDTH;
      csr_chan.data       = '0;
      cfg_line_width  = LINE_WIDTH_RST;
      cfg_page_height = PAGE_HEIGHT_RST;
      cfg_inverse     = 1'b0;
      acc_word    = '0;
      acc_fill    = 0;
      run_color   = 1'b0;
      line_pixels = 0;
      word_pos    = '0;
      line_num    = '0;
      line_closed = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: default settings, word boundaries, zero runs, padding
      add_run(5, 1'b0);
      add_run(27, 1'b0);
      add_run(3, 1'b0);
      add_run(0, 1'b0);
      add_run(4, 1'b1);
      // a whole line in one run, then an ignored run
      add_run(1728, 1'b0);
      add_run(10, 1'b1);
      // largest run overshoots; empty line
      add_run(16'hFFFF, 1'b1);
      add_run(0, 1'b1);
      // overshoot flushes a partial word
      add_run(100, 1'b0);
      add_run(2000, 1'b0);
      add_run(7, 1'b1);

      // zero width: nothing drawn
      write_reg(REG_LINE_WIDTH, 12'd0);
      add_run(5, 1'b0);
      add_run(3, 1'b1);
      // width clamped to the maximum, inverted colors, 64 words in one run
      write_reg(REG_LINE_WIDTH, 12'd4095);
      write_reg(REG_INVERSE, 1'b1);
      add_run(2048, 1'b1);
      // page height zero drops the line
      write_reg(REG_PAGE_HEIGHT, 12'd0);
      add_run(20, 1'b1);
      // width shrunk below the pixel total mid-line
      write_reg(REG_PAGE_HEIGHT, 12'd4095);
      write_reg(REG_LINE_WIDTH, 12'd40);
      add_run(30, 1'b0);
      write_reg(REG_LINE_WIDTH, 12'd20);
      add_run(1, 1'b1);
      // inverse flipped mid-line
      write_reg(REG_LINE_WIDTH, 12'd40);
      add_run(10, 1'b0);
      write_reg(REG_INVERSE, 1'b0);
      add_run(6, 1'b0);
      add_run(24, 1'b1);

      // Random: several settings, extremes among them
      random_phase(12'd37, 12'd4095, 1'b0, SINK_BUSY, 1'b1, 1'b0, 35);
      random_phase(12'd1, 12'd4095, 1'b1, SINK_PERIODIC, 1'b1, 1'b0, 25);
      random_phase(12'd2048, 12'd4095, 1'b0, SINK_ALWAYS, 1'b0, 1'b1, 40);
      random_phase(12'd4095, 12'd4095, 1'b1, SINK_SPARSE, 1'b1, 1'b0, 30);
      settle();
      random_phase(12'd96, line_num + 12'd3, 1'b0, SINK_BUSY, 1'b1, 1'b0, 30);
      random_phase(12'($urandom_range(32, 300)), 12'd4095, 1'($urandom_range(0, 1)),
                   SINK_BUSY, 1'b1, 1'b0, 45);
      settle();

      $display("Run summary: %0d runs over %0d line ends, %0d words checked, %0d errors",
               runs_taken, lines_taken, words_checked, error_count);
      $display("Widths 0 to 4095, both colors, dropped lines, overshoots, long stalls");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard limit on the run
   initial begin
      #10ms;
      $display("Timeout: %0d words still expected", expected_words.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
